/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define RBST_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rbst assertion failed");

// Implication whose consequence is checked at the next rising edge.
`define RBST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rbst assertion failed");

`endif

/* hw/rtl/rbst_pkg.sv */
`default_nettype none
package rbst_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned DiffW  = CoordW + 1;
    localparam int unsigned ProdW  = 2 * CoordW;
    localparam int unsigned FracW  = 16;
    localparam int unsigned InDataW  = 8 * CoordW;
    localparam int unsigned OutDataW = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    function automatic t_coord sat_shift(input logic signed [ProdW-1:0] p);
        logic [ProdW-FracW-CoordW:0] top;
        begin
            top = p[ProdW-1:FracW+CoordW-1];
            if ((top == '0) || (top == '1)) begin
                sat_shift = p[FracW+CoordW-1:FracW];
            end else if (p[ProdW-1]) begin
                sat_shift = {1'b1, {(CoordW-1){1'b0}}};
            end else begin
                sat_shift = {1'b0, {(CoordW-1){1'b1}}};
            end
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rbst_axis.sv */
`default_nettype none
module rbst_axis (
    input  wire                   i_clk,
    input  rbst_pkg::t_stage_en   i_en,
    input  rbst_pkg::t_coord      i_bound_min,
    input  rbst_pkg::t_coord      i_bound_max,
    input  rbst_pkg::t_coord      i_origin,
    input  rbst_pkg::t_coord      i_inv_dir,
    output rbst_pkg::t_coord      o_near,
    output rbst_pkg::t_coord      o_far
);
    import rbst_pkg::*;

    logic signed [DiffW-1:0]   r_diff_min;
    logic signed [DiffW-1:0]   r_diff_max;
    t_coord                    r_inv;
    logic signed [ProdW-1:0]   r_prod_min;
    logic signed [ProdW-1:0]   r_prod_max;
    t_coord                    r_near;
    t_coord                    r_far;
    logic signed [DiffW-1:0]   n_diff_min;
    logic signed [DiffW-1:0]   n_diff_max;
    logic signed [ProdW:0]     n_prod_min;
    logic signed [ProdW:0]     n_prod_max;
    t_coord                    d0;
    t_coord                    d1;

    assign n_diff_min = $signed({i_bound_min[CoordW-1], i_bound_min})
                      - $signed({i_origin[CoordW-1], i_origin});
    assign n_diff_max = $signed({i_bound_max[CoordW-1], i_bound_max})
                      - $signed({i_origin[CoordW-1], i_origin});
    assign n_prod_min = r_diff_min * r_inv;
    assign n_prod_max = r_diff_max * r_inv;
    assign d0 = sat_shift(r_prod_min);
    assign d1 = sat_shift(r_prod_max);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_diff_min <= n_diff_min;
            r_diff_max <= n_diff_max;
            r_inv      <= i_inv_dir;
        end
        if (i_en.s2) begin
            r_prod_min <= n_prod_min[ProdW-1:0];
            r_prod_max <= n_prod_max[ProdW-1:0];
        end
        if (i_en.s3) begin
            if (d1 < d0) begin
                r_near <= d1;
                r_far  <= d0;
            end else begin
                r_near <= d0;
                r_far  <= d1;
            end
        end
    end

    assign o_near = r_near;
    assign o_far  = r_far;

endmodule
`default_nettype wire

/* hw/rtl/ray_box_slab_test_top.sv */
// Ray against axis-aligned box slab test in signed Q16.16. An item with tuser 0 loads the
// ray origin (first three words of tdata) and inverse direction (next three); it gives no
// result and takes effect for every test item accepted after it. An item with tuser 1 tests
// a box (minimum corner, maximum corner, then t_low and t_high) and yields one result whose
// bit 0 is 1 on a hit. One item is taken per cycle unless output back-pressure stalls the
// pipeline; a test result passes through five register stages: slab difference, multiplier,
// shift with saturation and ordering, interval narrowing, final compare. Bubbles left by
// load items absorb output back-pressure. No item is taken while reset is asserted.
`default_nettype none
`include "assert_macros.svh"
module ray_box_slab_test_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, t_low, t_high
    input  wire [rbst_pkg::InDataW-1:0]   i_s_tdata,
    // req_type
    input  wire                           i_s_tuser,
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    // box_hit, zero padding
    output logic [rbst_pkg::OutDataW-1:0] o_m_tdata
);
    import rbst_pkg::*;

    t_coord    in_a [3];
    t_coord    in_b [3];
    t_coord    in_tl;
    t_coord    in_th;
    t_coord    near [3];
    t_coord    far  [3];
    t_coord    r_org [3];
    t_coord    r_inv [3];
    t_coord    r_tl [3];
    t_coord    r_th [3];
    t_coord    r_lo;
    t_coord    r_hi;
    t_coord    n_lo;
    t_coord    n_hi;
    logic      r_v1, r_v2, r_v3, r_v4, r_out_vld;
    logic      r_out_hit;
    logic      en1, en2, en3, en4, en_out;
    logic      accept;
    t_stage_en stage_en;

    assign in_tl = i_s_tdata[6*CoordW +: CoordW];
    assign in_th = i_s_tdata[7*CoordW +: CoordW];

    assign en_out = !r_out_vld || i_m_tready;
    assign en4    = !r_v4 || en_out;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_s_tvalid && en1 && i_rst_n;
    assign stage_en = '{s1: en1, s2: en2, s3: en3};

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign in_a[k] = i_s_tdata[k*CoordW +: CoordW];
        assign in_b[k] = i_s_tdata[(k+3)*CoordW +: CoordW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_org[k] <= '0;
                r_inv[k] <= '0;
            end else if (accept && (i_s_tuser == REQ_LOAD)) begin
                r_org[k] <= in_a[k];
                r_inv[k] <= in_b[k];
            end
        end

        rbst_axis u_axis (
            .i_clk       (i_clk),
            .i_en        (stage_en),
            .i_bound_min (in_a[k]),
            .i_bound_max (in_b[k]),
            .i_origin    (r_org[k]),
            .i_inv_dir   (r_inv[k]),
            .o_near      (near[k]),
            .o_far       (far[k])
        );
    end

    always_comb begin
        n_lo = r_tl[2];
        n_hi = r_th[2];
        for (int k = 0; k < 3; k++) begin
            if (near[k] > n_lo) begin
                n_lo = near[k];
            end
            if (far[k] < n_hi) begin
                n_hi = far[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_tl[0] <= in_tl;
            r_th[0] <= in_th;
        end
        if (en2) begin
            r_tl[1] <= r_tl[0];
            r_th[1] <= r_th[0];
        end
        if (en3) begin
            r_tl[2] <= r_tl[1];
            r_th[2] <= r_th[1];
        end
        if (en4) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (en_out) begin
            r_out_hit <= (r_hi > r_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && (i_s_tuser == REQ_TEST);
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en_out) begin
                r_out_vld <= r_v4;
            end
        end
    end

    assign o_s_tready = en1 && i_rst_n;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OutDataW-1){1'b0}}, r_out_hit};

    `RBST_ASSERT_IMP(a_stall_needs_backpressure, i_clk, i_rst_n,
        !o_s_tready, r_out_vld && !i_m_tready && r_v1 && r_v2 && r_v3 && r_v4)
    `RBST_ASSERT_NEXT(a_stage4_reaches_output, i_clk, i_rst_n,
        r_v4 && en_out, r_out_vld)
    `RBST_ASSERT_NEXT(a_load_makes_no_result, i_clk, i_rst_n,
        accept && (i_s_tuser == REQ_LOAD), !r_v1)

endmodule
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbst_pkg::*;

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord MAXC = 32'sh7fff_ffff;
    localparam t_coord MINC = 32'sh8000_0000;
    localparam t_coord NEG1 = 32'shffff_ffff;

    localparam int RAND_ITEMS   = 600;
    localparam int TAIL_ITEMS   = 80;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_LEN     = 80;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        bit           drain_first;
        logic         req;
        t_coord       t_hi;
        t_coord       t_lo;
        t_coord [2:0] b;
        t_coord [2:0] a;
    } ray_req_t;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic [InDataW-1:0]  i_s_tdata  = '0;
    logic                i_s_tuser  = 1'b0;
    logic                i_m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [OutDataW-1:0] o_m_tdata;

    ray_req_t pending[$];
    logic     hit_expected[$];
    ray_req_t in_flight;
    t_coord   ray_org [3] = '{default: '0};
    t_coord   ray_inv [3] = '{default: '0};
    bit       drain_next = 1'b0;
    int       n_accepted = 0;
    int       n_errors = 0;
    int       n_cycles = 0;
    int       src_gap = 0;
    int       sink_gap = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       src_idle_pct = 0;
    int       sink_idle_pct = 0;
    bit       quiet = 1'b0;

    ray_box_slab_test_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ((bound - origin) * inverse direction) >>> 16, saturated to 32 bits
    function automatic t_coord slab_time(input t_coord bound, input t_coord org,
                                         input t_coord inv);
        longint span;
        longint prod;
        longint t;
        span = longint'(bound) - longint'(org);
        prod = span * longint'(inv);
        t = prod >>> 16;
        if (t > longint'(MAXC)) return MAXC;
        if (t < longint'(MINC)) return MINC;
        return t_coord'(t);
    endfunction

    function automatic logic box_hit_of(input ray_req_t it);
        t_coord lo;
        t_coord hi;
        t_coord d0;
        t_coord d1;
        t_coord sw;
        logic   hit;
        lo = it.t_lo;
        hi = it.t_hi;
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (hit) begin
                d0 = slab_time(it.a[k], ray_org[k], ray_inv[k]);
                d1 = slab_time(it.b[k], ray_org[k], ray_inv[k]);
                if (d1 < d0) begin
                    sw = d0;
                    d0 = d1;
                    d1 = sw;
                end
                if (d0 > lo) lo = d0;
                if (d1 < hi) hi = d1;
                if (hi <= lo) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    task automatic apply_request(input ray_req_t it);
        if (it.req == REQ_TEST) begin
            hit_expected.push_back(box_hit_of(it));
        end else begin
            for (int k = 0; k < 3; k++) begin
                ray_org[k] = it.a[k];
                ray_inv[k] = it.b[k];
            end
        end
    endtask

    task automatic add_req(input logic req, input t_coord ax, input t_coord ay,
                           input t_coord az, input t_coord bx, input t_coord by,
                           input t_coord bz, input t_coord lo, input t_coord hi);
        ray_req_t it;
        it.drain_first = drain_next;
        it.req = req;
        it.a = {az, ay, ax};
        it.b = {bz, by, bx};
        it.t_lo = lo;
        it.t_hi = hi;
        pending.push_back(it);
        drain_next = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s (got %0d, want %0d)", n_cycles, what, got, want);
        n_errors++;
    endtask

    function automatic t_coord near(input int unsigned r);
        return t_coord'(int'($urandom_range(0, 2 * r)) - int'(r));
    endfunction

    function automatic t_coord corner_value();
        case ($urandom_range(0, 4))
            0: return MAXC;
            1: return MINC;
            2: return NEG1;
            3: return 32'sd1;
            default: return '0;
        endcase
    endfunction

    function automatic t_coord wild();
        case ($urandom_range(0, 3))
            0, 1: return t_coord'($urandom);
            2: return corner_value();
            default: return near(64 * ONE);
        endcase
    endfunction

    function automatic t_coord pick_inv();
        t_coord m;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return corner_value();
            default: begin
                m = t_coord'($urandom_range(ONE / 16, 16 * ONE));
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : pace
        n_cycles <= n_cycles + 1;
        quiet <= (pending.size() < TAIL_ITEMS);
        if (n_cycles % 64 == 0) begin
            src_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            sink_idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        end
        if (n_cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_requests
        logic go;
        go = 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            apply_request(in_flight);
            n_accepted++;
        end
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (i_s_tvalid && !o_s_tready) begin
            go = 1'b1;
        end else if (src_gap > 0) begin
            src_gap--;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain_first && hit_expected.size() != 0)) begin
            if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 2);
            end else begin
                in_flight = pending.pop_front();
                go = 1'b1;
            end
        end
        i_s_tvalid <= go;
        if (go) begin
            i_s_tdata <= {in_flight.t_hi, in_flight.t_lo, in_flight.b, in_flight.a};
            i_s_tuser <= in_flight.req;
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            i_m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_hits
        logic want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hit_expected.size() == 0) begin
                report_mismatch("result with none expected", o_m_tdata[0], 0);
            end else begin
                want = hit_expected.pop_front();
                if (o_m_tdata[0] !== want) begin
                    report_mismatch("box_hit", o_m_tdata[0], want);
                end
            end
        end
    end

    initial begin : stimulus
        t_coord gen_org [3];
        t_coord va [3];
        t_coord vb [3];
        t_coord ctr;
        t_coord half;
        t_coord lo;
        t_coord hi;
        int     n;
        gen_org = '{default: '0};

        add_req(REQ_TEST, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, '0, 100 * ONE);
        add_req(REQ_LOAD, '0, '0, '0, ONE, ONE, ONE, '0, '0);
        add_req(REQ_TEST, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, '0, 10 * ONE);
        add_req(REQ_TEST, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE);
        add_req(REQ_TEST, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 5 * ONE, '0);
        add_req(REQ_TEST, 2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE, '0, 10 * ONE);
        add_req(REQ_TEST, -2 * ONE, -2 * ONE, -2 * ONE, -ONE, -ONE, -ONE, '0, 10 * ONE);
        add_req(REQ_LOAD, MINC, MINC, MINC, MAXC, MAXC, MAXC, '0, '0);
        add_req(REQ_TEST, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC);
        add_req(REQ_LOAD, MAXC, MAXC, MAXC, MINC, MINC, MINC, '0, '0);
        add_req(REQ_TEST, MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC);
        add_req(REQ_LOAD, '0, '0, '0, NEG1, NEG1, NEG1, '0, '0);
        add_req(REQ_TEST, 32'sd1, 32'sd1, 32'sd1, NEG1, NEG1, NEG1, MINC, MAXC);
        add_req(REQ_LOAD, ONE, -ONE, 3 * ONE, -ONE, 2 * ONE, ONE / 2, '0, '0);
        add_req(REQ_TEST, -4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, '0, MAXC);
        add_req(REQ_TEST, '0, '0, '0, '0, '0, '0, '0, '0);
        add_req(REQ_TEST, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1);
        add_req(REQ_LOAD, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1);
        drain_next = 1'b1;
        add_req(REQ_TEST, '0, '0, '0, '0, '0, '0, MINC, MAXC);
        add_req(REQ_LOAD, '0, '0, '0, '0, '0, '0, MAXC, MINC);
        add_req(REQ_TEST, -ONE, -ONE, -ONE, ONE, ONE, ONE, MINC, MAXC);

        for (n = 0; n < RAND_ITEMS; n++) begin
            drain_next = ($urandom_range(0, 149) == 0);
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_req(REQ_LOAD, wild(), wild(), wild(), wild(), wild(), wild(),
                            wild(), wild());
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        gen_org[k] = near(16 * ONE);
                        vb[k] = pick_inv();
                    end
                    add_req(REQ_LOAD, gen_org[0], gen_org[1], gen_org[2],
                            vb[0], vb[1], vb[2], wild(), wild());
                end
            end else if ($urandom_range(0, 3) == 0) begin
                add_req(REQ_TEST, wild(), wild(), wild(), wild(), wild(), wild(),
                        wild(), wild());
            end else begin
                for (int k = 0; k < 3; k++) begin
                    ctr = gen_org[k] + near(8 * ONE);
                    half = t_coord'($urandom_range(0, 4 * ONE));
                    va[k] = ctr - half;
                    vb[k] = ctr + half;
                    if ($urandom_range(0, 7) == 0) begin
                        va[k] = ctr + half;
                        vb[k] = ctr - half;
                    end
                end
                case ($urandom_range(0, 3))
                    0: lo = MINC;
                    1: lo = near(4 * ONE);
                    default: lo = '0;
                endcase
                hi = $urandom_range(0, 1) ? MAXC : t_coord'($urandom_range(1, 64 * ONE));
                add_req(REQ_TEST, va[0], va[1], va[2], vb[0], vb[1], vb[2], lo, hi);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (hit_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
